// ===== hdl/abf_pkg.sv =====
// Shared constants, codes and types for the box versus frustum visibility test.
package abf_pkg;

  localparam int PLANE_COUNT = 6;
  localparam int COORD_W     = 32;
  localparam int FRAC_W      = 16;
  localparam int SLOT_W      = 3;
  localparam int LIMIT_W     = 32;
  localparam int PROD_W      = 2 * COORD_W;
  // Three products of up to 2^62 plus the scaled offset fit with two guard bits.
  localparam int SUM_W       = PROD_W + 2;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(1);

  typedef enum logic {
    REQ_LOAD = 1'b0,
    REQ_TEST = 1'b1
  } req_e;

  // One box traveling down the chain of plane cells, with the verdict so far.
  typedef struct packed {
    logic                       valid;
    logic                       box_ok;
    logic                       frustum_ok;
    logic                       outside;
    logic [2:0][COORD_W-1:0]    mn;
    logic [2:0][COORD_W-1:0]    mx;
  } abf_tok_t;

endpackage

// ===== hdl/abf_cell.sv =====
// One plane cell: holds a frustum plane and tests the passing box against it.
module abf_cell import abf_pkg::*; (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       load_i,
  input  logic signed [COORD_W-1:0]  normal_x_i,
  input  logic signed [COORD_W-1:0]  normal_y_i,
  input  logic signed [COORD_W-1:0]  normal_z_i,
  input  logic signed [COORD_W-1:0]  offset_d_i,
  input  logic [LIMIT_W-1:0]         limit_i,
  input  abf_tok_t                   tok_i,
  output abf_tok_t                   tok_o
);

  logic signed [COORD_W-1:0] n_q [3];
  logic signed [COORD_W-1:0] d_q;
  logic        [PROD_W-1:0]  sq_q [3];
  logic signed [PROD_W-1:0]  sq_d [3];
  logic signed [PROD_W-1:0]  prod_q [3];
  logic signed [PROD_W-1:0]  prod_d [3];
  logic signed [COORD_W-1:0] corner [3];
  abf_tok_t                  tok_a_q;
  abf_tok_t                  tok_b_q;
  abf_tok_t                  tok_b_d;
  logic signed [SUM_W-1:0]   sum;
  logic        [PROD_W-1:0]  len2;
  logic                      degen;

  // First stage: pick the corner farthest along the normal and multiply.
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      corner[k] = n_q[k][COORD_W-1] ? $signed(tok_i.mn[k]) : $signed(tok_i.mx[k]);
      prod_d[k] = n_q[k] * corner[k];
      sq_d[k]   = n_q[k] * n_q[k];
    end
  end

  // Second stage: exact signed distance and the degenerate-normal check.
  always_comb begin
    sum = SUM_W'(prod_q[0]) + SUM_W'(prod_q[1]) + SUM_W'(prod_q[2])
        + SUM_W'($signed({d_q, FRAC_W'(0)}));
    len2  = sq_q[0] + sq_q[1] + sq_q[2];
    degen = len2 <= PROD_W'(limit_i);
    tok_b_d            = tok_a_q;
    tok_b_d.frustum_ok = tok_a_q.frustum_ok & ~degen;
    tok_b_d.outside    = tok_a_q.outside | sum[SUM_W-1];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < 3; k++) begin
        n_q[k]  <= '0;
        sq_q[k] <= '0;
      end
      d_q     <= '0;
      tok_a_q <= '0;
      tok_b_q <= '0;
    end else begin
      if (load_i) begin
        n_q[0] <= normal_x_i;
        n_q[1] <= normal_y_i;
        n_q[2] <= normal_z_i;
        d_q    <= offset_d_i;
      end
      for (int k = 0; k < 3; k++) begin
        sq_q[k] <= sq_d[k];
      end
      tok_a_q <= tok_i;
      tok_b_q <= tok_b_d;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < 3; k++) begin
      prod_q[k] <= prod_d[k];
    end
  end

  assign tok_o = tok_b_q;

endmodule

// ===== hdl/aabb_frustum_visibility_test.sv =====
// Top level of the axis-aligned box versus frustum visibility test.
//
// Usage: one input channel (in_valid_i/in_ready_o) carries two kinds of item.
// A plane load (req_type_i = load) writes normal and offset into the cell
// named by plane_slot_i and returns nothing; slots at or beyond the plane
// count are dropped. A box test (req_type_i = test) returns one result on the
// output channel (out_valid_o/out_ready_i): visible, frustum_ok and box_ok.
// The degenerate limit is written through cfg_wdata_i; the user must write it only while idle, unenforced.
//
// Timing: a box runs down a chain of plane cells, two register stages per
// cell, then through a pending register into the output register. One box
// is in the chain at a time: a new box is taken only once the last result
// has moved on from the pending register. Ready stays high after a load.
// A load writes its plane at the edge where it transfers, so a box taken later
// already meets the new plane; the input channel carries one item at a time.
//
// Reset clears all planes to zero (so the frustum reads degenerate until all
// slots are loaded) and sets the limit to one. While the receiver stalls, the
// result sits in the output register, the next box can still be taken, and
// its result waits in the pending register, holding off further input.
module aabb_frustum_visibility_test import abf_pkg::*; (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic                       req_type_i,
  input  logic [SLOT_W-1:0]          plane_slot_i,
  input  logic signed [COORD_W-1:0]  normal_x_i,
  input  logic signed [COORD_W-1:0]  normal_y_i,
  input  logic signed [COORD_W-1:0]  normal_z_i,
  input  logic signed [COORD_W-1:0]  offset_d_i,
  input  logic signed [COORD_W-1:0]  min_x_i,
  input  logic signed [COORD_W-1:0]  min_y_i,
  input  logic signed [COORD_W-1:0]  min_z_i,
  input  logic signed [COORD_W-1:0]  max_x_i,
  input  logic signed [COORD_W-1:0]  max_y_i,
  input  logic signed [COORD_W-1:0]  max_z_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic                       visible_o,
  output logic                       frustum_ok_o,
  output logic                       box_ok_o,
  input  logic                       cfg_we_i,
  input  logic [LIMIT_W-1:0]         cfg_wdata_i
);

  abf_tok_t                   tok [PLANE_COUNT+1];
  logic [PLANE_COUNT-1:0]     load_we;
  logic [LIMIT_W-1:0]         limit_q;
  logic                       busy_q, busy_d;
  logic                       pend_valid_q, pend_valid_d;
  logic                       pend_vis_q, pend_fok_q, pend_bok_q;
  logic                       out_valid_q, out_valid_d;
  logic                       out_vis_q, out_fok_q, out_bok_q;
  logic                       in_xfer;
  logic                       is_test;
  logic                       box_ok;
  logic                       move;
  abf_tok_t                   tail;
  logic                       tail_vis;

  assign in_ready_o = ~busy_q;
  assign in_xfer    = in_valid_i & in_ready_o;
  assign is_test    = req_e'(req_type_i) == REQ_TEST;
  assign box_ok     = (min_x_i <= max_x_i) & (min_y_i <= max_y_i) & (min_z_i <= max_z_i);

  // A box enters the first cell straight from the input transfer.
  always_comb begin
    tok[0]            = '0;
    tok[0].valid      = in_xfer & is_test;
    tok[0].box_ok     = box_ok;
    tok[0].frustum_ok = 1'b1;
    tok[0].outside    = 1'b0;
    tok[0].mn[0]      = min_x_i;
    tok[0].mn[1]      = min_y_i;
    tok[0].mn[2]      = min_z_i;
    tok[0].mx[0]      = max_x_i;
    tok[0].mx[1]      = max_y_i;
    tok[0].mx[2]      = max_z_i;
  end

  for (genvar g = 0; g < PLANE_COUNT; g++) begin : g_cell
    assign load_we[g] = in_xfer & ~is_test & (32'(plane_slot_i) == g);

    abf_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .load_i     (load_we[g]),
      .normal_x_i (normal_x_i),
      .normal_y_i (normal_y_i),
      .normal_z_i (normal_z_i),
      .offset_d_i (offset_d_i),
      .limit_i    (limit_q),
      .tok_i      (tok[g]),
      .tok_o      (tok[g+1])
    );
  end

  // Final verdict: a degenerate frustum always draws; otherwise an inverted box never does.
  assign tail     = tok[PLANE_COUNT];
  assign tail_vis = ~tail.frustum_ok | (tail.box_ok & ~tail.outside);

  // The pending result moves on whenever the output register is free or drained.
  assign move = pend_valid_q & (~out_valid_q | out_ready_i);

  always_comb begin
    busy_d       = busy_q;
    pend_valid_d = pend_valid_q;
    out_valid_d  = out_valid_q;
    if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (move) begin
      out_valid_d  = 1'b1;
      pend_valid_d = 1'b0;
      busy_d       = 1'b0;
    end
    if (tail.valid) begin
      pend_valid_d = 1'b1;
    end
    if (in_xfer && is_test) begin
      busy_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q      <= LIMIT_RESET;
      busy_q       <= 1'b0;
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        limit_q <= cfg_wdata_i;
      end
      busy_q       <= busy_d;
      pend_valid_q <= pend_valid_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (tail.valid) begin
      pend_vis_q <= tail_vis;
      pend_fok_q <= tail.frustum_ok;
      pend_bok_q <= tail.box_ok;
    end
    if (move) begin
      out_vis_q <= pend_vis_q;
      out_fok_q <= pend_fok_q;
      out_bok_q <= pend_bok_q;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign visible_o    = out_vis_q;
  assign frustum_ok_o = out_fok_q;
  assign box_ok_o     = out_bok_q;

endmodule

// ===== hdl/abf_checker.sv =====
// Port-level assertions for the visibility test, bound to the top level.
module abf_checker import abf_pkg::*; (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       in_valid_i,
  input logic                       in_ready_o,
  input logic                       req_type_i,
  input logic                       out_valid_o,
  input logic                       out_ready_i,
  input logic                       visible_o,
  input logic                       frustum_ok_o,
  input logic                       box_ok_o
);

  // A stalled result stays offered.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result dropped while stalled");

  // A degenerate frustum forces the box to be drawn.
  a_degen_vis: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !frustum_ok_o |-> visible_o)
    else $error("degenerate frustum did not force visible");

  // With a sound frustum, an inverted box is never drawn.
  a_inverted: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && frustum_ok_o && !box_ok_o |-> !visible_o)
    else $error("inverted box reported visible");

  // A box transfer occupies the chain, so input is held off next cycle.
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && (req_e'(req_type_i) == REQ_TEST) |=> !in_ready_o)
    else $error("second box taken while chain busy");

endmodule

bind aabb_frustum_visibility_test abf_checker u_abf_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_valid_i),
  .in_ready_o   (in_ready_o),
  .req_type_i   (req_type_i),
  .out_valid_o  (out_valid_o),
  .out_ready_i  (out_ready_i),
  .visible_o    (visible_o),
  .frustum_ok_o (frustum_ok_o),
  .box_ok_o     (box_ok_o)
);

// ===== bench/abf_tb_pkg.sv =====
// Request and verdict types plus the scoreboard for the box culling bench.
package abf_tb_pkg;
  import abf_pkg::*;

  typedef struct {
    req_e              kind;
    logic [SLOT_W-1:0] slot;
    int                norm [3];
    int                ofs;
    int                lo [3];
    int                hi [3];
  } cull_req_t;

  typedef struct packed {
    logic visible;
    logic frustum_ok;
    logic box_ok;
  } cull_verdict_t;

  class cull_scoreboard;
    int                 plane_normal [PLANE_COUNT][3];
    int                 plane_offset [PLANE_COUNT];
    logic [LIMIT_W-1:0] degenerate_limit;
    cull_verdict_t      pending_verdicts [$];
    int                 error_count;
    int                 verdicts_checked;

    function new();
      for (int p = 0; p < PLANE_COUNT; p++) begin
        plane_offset[p] = 0;
        for (int a = 0; a < 3; a++) plane_normal[p][a] = 0;
      end
      degenerate_limit = LIMIT_RESET;
      error_count = 0;
      verdicts_checked = 0;
    endfunction

    function void set_limit(logic [LIMIT_W-1:0] value);
      degenerate_limit = value;
    endfunction

    function int outstanding();
      return pending_verdicts.size();
    endfunction

    // Squared length in Q32.32; three squares of at most 2^62 fit in 64 bits.
    function bit plane_degenerate(int p);
      longint unsigned len2;
      len2 = 0;
      for (int a = 0; a < 3; a++)
        len2 += longint'(plane_normal[p][a]) * longint'(plane_normal[p][a]);
      return len2 <= {32'b0, degenerate_limit};
    endfunction

    // Uses the corner farthest along the normal; the sum is exact in 68 bits.
    function bit box_behind_plane(int p, cull_req_t r);
      logic signed [67:0] signed_dist;
      longint             corner;
      signed_dist = 0;
      for (int a = 0; a < 3; a++) begin
        corner = (plane_normal[p][a] >= 0) ? r.hi[a] : r.lo[a];
        signed_dist += longint'(plane_normal[p][a]) * corner;
      end
      signed_dist += longint'(plane_offset[p]) * 65536;
      return signed_dist < 0;
    endfunction

    function void take_request(cull_req_t r);
      cull_verdict_t v;
      if (r.kind == REQ_LOAD) begin
        if (r.slot < PLANE_COUNT) begin
          for (int a = 0; a < 3; a++) plane_normal[r.slot][a] = r.norm[a];
          plane_offset[r.slot] = r.ofs;
        end
        return;
      end
      v.box_ok = (r.lo[0] <= r.hi[0]) && (r.lo[1] <= r.hi[1]) && (r.lo[2] <= r.hi[2]);
      v.frustum_ok = 1'b1;
      for (int p = 0; p < PLANE_COUNT; p++)
        if (plane_degenerate(p)) v.frustum_ok = 1'b0;
      if (!v.frustum_ok) begin
        v.visible = 1'b1;
      end else if (!v.box_ok) begin
        v.visible = 1'b0;
      end else begin
        v.visible = 1'b1;
        for (int p = 0; p < PLANE_COUNT; p++)
          if (box_behind_plane(p, r)) v.visible = 1'b0;
      end
      pending_verdicts.push_back(v);
    endfunction

    function void report_field(string name, logic want, logic got);
      if (want !== got) begin
        $display("%0t: %s mismatch, expected %0b, actual %0b", $time, name, want, got);
        error_count++;
      end
    endfunction

    function void check_verdict(cull_verdict_t got);
      cull_verdict_t want;
      verdicts_checked++;
      if (pending_verdicts.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %b", $time, got);
        error_count++;
        return;
      end
      want = pending_verdicts.pop_front();
      report_field("visible", want.visible, got.visible);
      report_field("frustum_ok", want.frustum_ok, got.frustum_ok);
      report_field("box_ok", want.box_ok, got.box_ok);
    endfunction
  endclass

endpackage

// ===== bench/testbench.sv =====
// Top-level bench for the box versus frustum visibility test.
module testbench;
  import abf_pkg::*;
  import abf_tb_pkg::*;

  localparam int CLK_PERIOD = 20;
  // Allow some slack after the last result before touching the limit register
  // or finishing.
  localparam int SETTLE_CYCLES = 2 * PLANE_COUNT + 6;
  localparam int LONG_HOLD = 300;
  localparam int TIMEOUT_CYCLES = 400000;
  localparam int ONE = 1 << FRAC_W;
  localparam int TEN = 10 * ONE;
  localparam int MAX_C = int'(32'h7fff_ffff);
  localparam int MIN_C = int'(32'h8000_0000);

  bit clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic req_type = REQ_LOAD;
  logic [SLOT_W-1:0] plane_slot = '0;
  logic signed [COORD_W-1:0] normal_x = '0, normal_y = '0, normal_z = '0, offset_d = '0;
  logic signed [COORD_W-1:0] min_x = '0, min_y = '0, min_z = '0;
  logic signed [COORD_W-1:0] max_x = '0, max_y = '0, max_z = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic visible, frustum_ok, box_ok;
  logic cfg_we = 1'b0;
  logic [LIMIT_W-1:0] cfg_wdata = '0;

  cull_scoreboard sb;
  // Random idling is switched off for the final phase so the block also runs
  // at its full rate for a while.
  bit idle_enabled = 1'b1;
  bit sender_calm = 1'b0;
  int items_sent = 0;

  always #(CLK_PERIOD / 2) clk = ~clk;

  aabb_frustum_visibility_test dut (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_ready_o   (in_ready),
    .req_type_i   (req_type),
    .plane_slot_i (plane_slot),
    .normal_x_i   (normal_x),
    .normal_y_i   (normal_y),
    .normal_z_i   (normal_z),
    .offset_d_i   (offset_d),
    .min_x_i      (min_x),
    .min_y_i      (min_y),
    .min_z_i      (min_z),
    .max_x_i      (max_x),
    .max_y_i      (max_y),
    .max_z_i      (max_z),
    .out_valid_o  (out_valid),
    .out_ready_i  (out_ready),
    .visible_o    (visible),
    .frustum_ok_o (frustum_ok),
    .box_ok_o     (box_ok),
    .cfg_we_i     (cfg_we),
    .cfg_wdata_i  (cfg_wdata)
  );

  // A full-range word that lands on the signed extremes, zero and minus one
  // noticeably often.
  function automatic int pick_word();
    case ($urandom_range(0, 7))
      0: return MIN_C;
      1: return MAX_C;
      2: return 0;
      3: return -1;
      default: return int'($urandom);
    endcase
  endfunction

  function automatic int rand_span(int span);
    return int'($urandom_range(0, 2 * span)) - span;
  endfunction

  // Every field is filled with noise, so the fields that a request kind does
  // not use still toggle through all their bits.
  function automatic cull_req_t noise_request();
    cull_req_t r;
    r.kind = req_e'($urandom_range(0, 1));
    r.slot = SLOT_W'($urandom_range(0, 7));
    r.ofs  = pick_word();
    for (int a = 0; a < 3; a++) begin
      r.norm[a] = pick_word();
      r.lo[a]   = pick_word();
      r.hi[a]   = pick_word();
    end
    return r;
  endfunction

  // A plane with a normal of length up to a few units and, mostly, a positive
  // offset, so that a region around the origin stays inside the frustum.
  function automatic cull_req_t plane_request(int slot);
    cull_req_t r;
    r = noise_request();
    r.kind = REQ_LOAD;
    r.slot = SLOT_W'(slot);
    for (int a = 0; a < 3; a++)
      r.norm[a] = ($urandom_range(0, 7) == 0) ? 0 : rand_span(2 * ONE);
    r.ofs = int'($urandom_range(0, 200 * ONE));
    if ($urandom_range(0, 9) == 0) r.ofs = -r.ofs;
    return r;
  endfunction

  // A box near the origin; some have zero extent on an axis, some inverted on one axis.
  function automatic cull_req_t box_request();
    cull_req_t r;
    int c, h, a, t;
    r = noise_request();
    r.kind = REQ_TEST;
    for (a = 0; a < 3; a++) begin
      c = rand_span(200 * ONE);
      h = ($urandom_range(0, 15) == 0) ? 0 : int'($urandom_range(0, 60 * ONE));
      r.lo[a] = c - h;
      r.hi[a] = c + h;
    end
    if ($urandom_range(0, 9) == 0) begin
      a = $urandom_range(0, 2);
      t = r.lo[a];
      r.lo[a] = r.hi[a];
      r.hi[a] = t;
    end
    return r;
  endfunction

  function automatic cull_req_t load_req(int slot, int nx, int ny, int nz, int d);
    cull_req_t r;
    r = noise_request();
    r.kind = REQ_LOAD;
    r.slot = SLOT_W'(slot);
    r.norm = '{nx, ny, nz};
    r.ofs = d;
    return r;
  endfunction

  function automatic cull_req_t box_req(int lx, int ly, int lz, int hx, int hy, int hz);
    cull_req_t r;
    r = noise_request();
    r.kind = REQ_TEST;
    r.lo = '{lx, ly, lz};
    r.hi = '{hx, hy, hz};
    return r;
  endfunction

  // Offers one request and returns at the edge where it transfers. Valid is
  // left high, so a request that follows at once keeps the channel busy
  // without a bubble; any gap lowers valid first.
  task automatic send_request(cull_req_t r);
    if (idle_enabled && !sender_calm && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
    in_valid   <= 1'b1;
    req_type   <= r.kind;
    plane_slot <= r.slot;
    normal_x   <= r.norm[0];
    normal_y   <= r.norm[1];
    normal_z   <= r.norm[2];
    offset_d   <= r.ofs;
    min_x      <= r.lo[0];
    min_y      <= r.lo[1];
    min_z      <= r.lo[2];
    max_x      <= r.hi[0];
    max_y      <= r.hi[1];
    max_z      <= r.hi[2];
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.take_request(r);
    // Loads to a slot past the plane count are dropped by the block.
    if (!(r.kind == REQ_LOAD && r.slot >= PLANE_COUNT)) items_sent++;
  endtask

  // Stops offering, waits for every outstanding verdict, then lets the plane
  // chain run empty, since a trailing load produces no result to wait for.
  task automatic wait_for_results();
    in_valid <= 1'b0;
    while (sb.outstanding() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // The limit register is only written while the block is idle.
  task automatic write_limit(logic [LIMIT_W-1:0] value);
    wait_for_results();
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    sb.set_limit(value);
    cfg_we <= 1'b0;
  endtask

  task automatic directed_checks();
    // Straight out of reset every plane is zero, so the frustum is degenerate:
    // boxes are visible, and box_ok still reports an inverted box.
    send_request(box_req(MIN_C, MIN_C, MIN_C, MAX_C, MAX_C, MAX_C));
    send_request(box_req(MAX_C, 0, 0, MIN_C, 0, 0));
    // An axis-aligned frustum: the cube from -10 to 10 on every axis.
    send_request(load_req(0, ONE, 0, 0, TEN));
    send_request(load_req(1, -ONE, 0, 0, TEN));
    send_request(load_req(2, 0, ONE, 0, TEN));
    send_request(load_req(3, 0, -ONE, 0, TEN));
    send_request(load_req(4, 0, 0, ONE, TEN));
    send_request(load_req(5, 0, 0, -ONE, TEN));
    // Loads past the last slot must leave the frustum alone.
    send_request(load_req(6, 0, 0, 0, 0));
    send_request(load_req(7, MIN_C, MIN_C, MIN_C, MIN_C));
    send_request(box_req(-ONE, -ONE, -ONE, ONE, ONE, ONE));
    // Touching the x = -10 plane counts as visible; one LSB beyond is culled.
    send_request(box_req(-2 * TEN, -ONE, -ONE, -TEN, ONE, ONE));
    send_request(box_req(-2 * TEN, -ONE, -ONE, -TEN - 1, ONE, ONE));
    send_request(box_req(-ONE, 2 * ONE, -ONE, ONE, ONE, ONE));
    send_request(box_req(MAX_C, MAX_C, MAX_C, MAX_C, MAX_C, MAX_C));
    // Extreme normal and offset push the exact sum to its widest.
    send_request(load_req(2, MIN_C, MAX_C, MIN_C, MIN_C));
    send_request(box_req(MIN_C, MIN_C, MIN_C, MAX_C, MAX_C, MAX_C));
    send_request(box_req(0, 0, 0, 0, 0, 0));
    send_request(load_req(2, 0, ONE, 0, TEN));
    // With a zero limit only an all-zero normal is degenerate.
    write_limit('0);
    send_request(load_req(3, 0, 0, 0, TEN));
    send_request(box_req(-ONE, -ONE, -ONE, ONE, ONE, ONE));
    // Largest limit: a unit normal passes, one LSB shorter does not, and the
    // limit is then moved across that normal's squared length.
    write_limit('1);
    send_request(load_req(3, 0, -ONE, 0, TEN));
    send_request(load_req(4, 0, 0, ONE - 1, TEN));
    send_request(box_req(-ONE, -ONE, -ONE, ONE, ONE, ONE));
    write_limit(32'hFFFE_0000);
    send_request(box_req(-ONE, -ONE, -ONE, ONE, ONE, ONE));
    write_limit(32'hFFFE_0001);
    send_request(box_req(-ONE, -ONE, -ONE, ONE, ONE, ONE));
  endtask

  // Mostly a fresh frustum followed by a run of boxes against it; some plane
  // loads are skipped so older planes carry over. The rest is pure noise.
  task automatic random_phase(logic [LIMIT_W-1:0] limit, int quota);
    int start_count;
    write_limit(limit);
    start_count = items_sent;
    while (items_sent - start_count < quota) begin
      sender_calm = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 3) != 0) begin
        for (int s = 0; s < PLANE_COUNT; s++)
          if ($urandom_range(0, 4) != 0) send_request(plane_request(s));
        repeat ($urandom_range(4, 12)) send_request(box_request());
      end else begin
        repeat ($urandom_range(1, 6)) send_request(noise_request());
      end
    end
  endtask

  initial begin
    sb = new();
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    directed_checks();
    random_phase(LIMIT_RESET, 250);
    random_phase('0, 250);
    random_phase($urandom, 250);
    random_phase('1, 250);
    idle_enabled = 1'b0;
    random_phase(32'h4000_0000, 250);
    wait_for_results();
    if (sb.error_count == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

  // Result side: checks every transfer and applies back-pressure. Two long
  // holds, counted here in cycles, let the block fill up and stall its input
  // while the sender keeps offering requests.
  initial begin
    cull_verdict_t got;
    int stall_left;
    int long_holds;
    stall_left = 0;
    long_holds = 0;
    forever begin
      @(posedge clk);
      if (out_valid && out_ready) begin
        got.visible    = visible;
        got.frustum_ok = frustum_ok;
        got.box_ok     = box_ok;
        sb.check_verdict(got);
      end
      if (stall_left > 0) begin
        stall_left--;
      end else if ((long_holds == 0 && sb.verdicts_checked >= 60) ||
                   (long_holds == 1 && sb.verdicts_checked >= 300)) begin
        stall_left = LONG_HOLD;
        long_holds++;
      end else if (idle_enabled && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(1, 13);
      end
      out_ready <= (stall_left == 0);
    end
  end

  // Watchdog: a hung handshake ends the run as a failure.
  initial begin
    #(CLK_PERIOD * TIMEOUT_CYCLES);
    $display("%0t: timeout, the run did not complete", $time);
    $display("testbench NOT OK");
    $finish;
  end

endmodule

// ===== filelist.f =====
hdl/abf_pkg.sv
hdl/abf_cell.sv
hdl/aabb_frustum_visibility_test.sv
hdl/abf_checker.sv
bench/abf_tb_pkg.sv
bench/testbench.sv
